FILE: rtl/core/cbd_pkg.sv
package cbd_pkg;

  // Fixed widths of the register file and the data path.
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int FACTOR_W   = 9;
  localparam int PIX_W      = 32;
  localparam int TIDX_W     = 24;
  localparam int CHAN_W     = 8;

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Factor value that means 1.0.
  localparam logic [FACTOR_W-1:0] FACTOR_ONE = 9'd256;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 4'd0,
    REG_ORIGIN_Y     = 4'd1,
    REG_IMAGE_COLS   = 4'd2,
    REG_IMAGE_ROWS   = 4'd3,
    REG_SCREEN_COLS  = 4'd4,
    REG_SCREEN_ROWS  = 4'd5,
    REG_DARKEN_MODE  = 4'd6,
    REG_SCALE_FACTOR = 4'd7
  } cfg_reg_e;

  // Settings used by the front: origin, clamped image and screen sizes.
  typedef struct packed {
    logic [CFG_W-1:0] origin_x;
    logic [CFG_W-1:0] origin_y;
    logic [CFG_W-1:0] image_cols;
    logic [CFG_W-1:0] image_rows;
    logic [CFG_W-1:0] screen_cols;
    logic [CFG_W-1:0] screen_rows;
  } front_cfg_t;

  // Settings used by the back: row stride and color scaling.
  typedef struct packed {
    logic [CFG_W-1:0]    stride;
    logic                darken;
    logic [FACTOR_W-1:0] factor;
  } back_cfg_t;

  // One visible pixel request: screen position and source word.
  typedef struct packed {
    logic [CFG_W-1:0] pos_x;
    logic [CFG_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel;
  } blit_req_t;

endpackage

FILE: rtl/core/cbd_front.sv
module cbd_front
  import cbd_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  front_cfg_t cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [PIX_W-1:0] source_pixel_i,
  input  logic       q_full_i,
  output logic       push_o,
  output blit_req_t  push_req_o
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int EXT_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam int POS_W = EXT_W + 1;

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic             accept;
  logic [EXT_W-1:0] col_next, row_next;
  logic signed [POS_W-1:0] sx, sy;
  logic             visible;

  // The front holds off new pixels only while the queue is full.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Screen position of the current pixel.
  assign sx = POS_W'(signed'(cfg_i.origin_x)) + signed'(POS_W'(col_q));
  assign sy = POS_W'(signed'(cfg_i.origin_y)) + signed'(POS_W'(row_q));

  // Clip against the screen; a zero screen size hides every pixel.
  assign visible = !sx[POS_W-1] && !sy[POS_W-1]
                && (POS_W'(sx) < POS_W'(cfg_i.screen_cols))
                && (POS_W'(sy) < POS_W'(cfg_i.screen_rows));

  assign push_o           = accept && visible;
  assign push_req_o.pos_x = sx[CFG_W-1:0];
  assign push_req_o.pos_y = sy[CFG_W-1:0];
  assign push_req_o.pixel = source_pixel_i;

  // Raster position: column wraps at the image width, row at the height.
  assign col_next = EXT_W'(col_q) + EXT_W'(1);
  assign row_next = EXT_W'(row_q) + EXT_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_next >= EXT_W'(cfg_i.image_cols)) begin
        col_d = '0;
        if (row_next >= EXT_W'(cfg_i.image_rows)) begin
          row_d = '0;
        end else begin
          row_d = row_next[CNT_W-1:0];
        end
      end else begin
        col_d = col_next[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: rtl/core/cbd_queue.sv
module cbd_queue
  import cbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  blit_req_t push_req_i,
  output logic      full_o,
  output logic      valid_o,
  input  logic      pop_i,
  output blit_req_t pop_req_o
);

  blit_req_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_req_o = mem_q[rd_ptr_q];

  // Storage of the queued requests.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/cbd_back.sv
module cbd_back
  import cbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  back_cfg_t cfg_i,
  input  logic      q_valid_i,
  input  blit_req_t q_req_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [TIDX_W-1:0] target_index_o,
  output logic [PIX_W-1:0]  target_pixel_o
);

  localparam int PROD_W = 2 * CFG_W;
  localparam int SCL_W  = CHAN_W + FACTOR_W;

  logic                out_valid_q;
  logic [TIDX_W-1:0]   index_q;
  logic [PIX_W-1:0]    pixel_q;
  logic [PROD_W-1:0]   row_base, index_sum;
  logic [SCL_W-1:0]    red_s, green_s, blue_s;
  logic [PIX_W-1:0]    word;

  // Take a request whenever the output register is free or being drained.
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  // Framebuffer index: row times stride plus column, low bits kept.
  assign row_base  = PROD_W'(q_req_i.pos_y) * PROD_W'(cfg_i.stride);
  assign index_sum = row_base + PROD_W'(q_req_i.pos_x);

  // Each color channel is scaled; bits 15:8 of the product are kept.
  assign red_s   = SCL_W'(q_req_i.pixel[23:16]) * SCL_W'(cfg_i.factor);
  assign green_s = SCL_W'(q_req_i.pixel[15:8])  * SCL_W'(cfg_i.factor);
  assign blue_s  = SCL_W'(q_req_i.pixel[7:0])   * SCL_W'(cfg_i.factor);

  always_comb begin
    if (cfg_i.darken) begin
      word = {8'h00, red_s[15:8], green_s[15:8], blue_s[15:8]};
    end else begin
      word = q_req_i.pixel;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      index_q <= index_sum[TIDX_W-1:0];
      pixel_q <= word;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_index_o = index_q;
  assign target_pixel_o = pixel_q;

endmodule

FILE: rtl/core/clipped_blit_with_darken.sv
// Clipped image blit with optional darkening.
// Source pixels enter in raster order on the input request channel
// (in_valid_i / in_stall_o / source_pixel_i); the block tracks the image
// column and row itself. Pixels that land on the screen leave on the output
// channel (out_valid_o / out_stall_i) as a framebuffer index and a word;
// pixels off screen are dropped and produce no request.
// Throughput is one pixel per clock while in_stall_o is low. A visible pixel
// accepted on the input passes a two-entry request queue and then the output
// register, where the index multiply and the channel multiplies sit.
// When the receiver stalls, the output register holds its request and the
// queue absorbs up to two more; then in_stall_o rises until the output drains.
// Reset clears the position counters, the queue and the output valid, and
// loads the register defaults: origin 0, image 1 x 1, screen 1920 x 1080,
// copy mode, factor 1.0. Registers are written through cfg_we_i only while
// idle; the user must keep to this, as the block does not enforce it.
module clipped_blit_with_darken
  import cbd_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     source_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TIDX_W-1:0]    target_index_o,
  output logic [PIX_W-1:0]     target_pixel_o
);

  logic [CFG_W-1:0]    origin_x_q, origin_y_q;
  logic [CFG_W-1:0]    image_cols_q, image_rows_q;
  logic [CFG_W-1:0]    screen_cols_q, screen_rows_q;
  logic                darken_q;
  logic [FACTOR_W-1:0] factor_q;

  front_cfg_t front_cfg;
  back_cfg_t  back_cfg;
  logic       q_full, q_valid, push, pop;
  blit_req_t  push_req, pop_req;

  // Size clamp: zero maps to the given value, anything above MAX_DIM to MAX_DIM.
  function automatic logic [CFG_W-1:0] dim_clamp(logic [CFG_W-1:0] v,
                                                 logic [CFG_W-1:0] zero_as);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = zero_as;
    end else if (32'(v) > MAX_DIM) begin
      r = CFG_W'(MAX_DIM);
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      image_cols_q  <= CFG_W'(1);
      image_rows_q  <= CFG_W'(1);
      screen_cols_q <= CFG_W'(1920);
      screen_rows_q <= CFG_W'(1080);
      darken_q      <= 1'b0;
      factor_q      <= FACTOR_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X:     origin_x_q    <= cfg_data_i;
        REG_ORIGIN_Y:     origin_y_q    <= cfg_data_i;
        REG_IMAGE_COLS:   image_cols_q  <= cfg_data_i;
        REG_IMAGE_ROWS:   image_rows_q  <= cfg_data_i;
        REG_SCREEN_COLS:  screen_cols_q <= cfg_data_i;
        REG_SCREEN_ROWS:  screen_rows_q <= cfg_data_i;
        REG_DARKEN_MODE:  darken_q      <= cfg_data_i[0];
        REG_SCALE_FACTOR: factor_q      <= cfg_data_i[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped views of the registers for each side.
  always_comb begin
    front_cfg.origin_x    = origin_x_q;
    front_cfg.origin_y    = origin_y_q;
    front_cfg.image_cols  = dim_clamp(image_cols_q, CFG_W'(1));
    front_cfg.image_rows  = dim_clamp(image_rows_q, CFG_W'(1));
    front_cfg.screen_cols = dim_clamp(screen_cols_q, '0);
    front_cfg.screen_rows = dim_clamp(screen_rows_q, '0);
    back_cfg.stride       = front_cfg.screen_cols;
    back_cfg.darken       = darken_q;
    back_cfg.factor       = (factor_q > FACTOR_ONE) ? FACTOR_ONE : factor_q;
  end

  cbd_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (front_cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_pixel_i(source_pixel_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_req_o    (push_req)
  );

  cbd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_req_i(push_req),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .pop_i     (pop),
    .pop_req_o (pop_req)
  );

  cbd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (back_cfg),
    .q_valid_i     (q_valid),
    .q_req_i       (pop_req),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .target_index_o(target_index_o),
    .target_pixel_o(target_pixel_o)
  );

endmodule

FILE: verif/clipped_blit_with_darken_checker.sv
`timescale 1ns / 1ps

// Watches the register port and both request channels of the blit block.
// It keeps its own copy of the registers and of the image position, works
// out the framebuffer write that each accepted source pixel should cause,
// and compares every output request with the oldest write still owed.
module clipped_blit_with_darken_checker
  import cbd_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [PIX_W-1:0]     source_pixel_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [TIDX_W-1:0]    target_index_i,
  input  logic [PIX_W-1:0]     target_pixel_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [TIDX_W-1:0] index;
    logic [PIX_W-1:0]  pixel;
  } fb_write_t;

  // Register copy and image position.
  logic signed [CFG_W-1:0] origin_x;
  logic signed [CFG_W-1:0] origin_y;
  logic [CFG_W-1:0]        image_cols;
  logic [CFG_W-1:0]        image_rows;
  logic [CFG_W-1:0]        screen_cols;
  logic [CFG_W-1:0]        screen_rows;
  logic                    darken;
  logic [FACTOR_W-1:0]     factor;
  int                      col_pos;
  int                      row_pos;

  fb_write_t owed_writes[$];
  int        failures;

  // Sizes of zero count as zero_as; sizes above the maximum are capped.
  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int zero_as);
    if (v == '0) return zero_as;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // One color channel times the factor, truncated back to eight bits.
  function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                   input logic [FACTOR_W-1:0] f);
    logic [16:0] prod;
    prod = 17'(c) * 17'(f);
    return prod[15:8];
  endfunction

  // Screen placement of the current pixel; returns 0 when it is clipped away.
  function automatic bit blit_target(input logic [PIX_W-1:0] pix, output fb_write_t wr);
    int                  scw;
    int                  sch;
    int                  sx;
    int                  sy;
    logic [FACTOR_W-1:0] f;
    logic [PIX_W-1:0]    word;
    scw = clamp_dim(screen_cols, 0);
    sch = clamp_dim(screen_rows, 0);
    sx = int'(origin_x) + col_pos;
    sy = int'(origin_y) + row_pos;
    wr = '0;
    if (sx < 0 || sy < 0 || sx >= scw || sy >= sch) return 1'b0;
    word = pix;
    if (darken) begin
      f = (factor > FACTOR_ONE) ? FACTOR_ONE : factor;
      word = {8'h00, scale_chan(pix[23:16], f), scale_chan(pix[15:8], f),
              scale_chan(pix[7:0], f)};
    end
    wr.index = TIDX_W'(sy * scw + sx);
    wr.pixel = word;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input logic [PIX_W-1:0] want,
                                 input logic [PIX_W-1:0] got);
    failures++;
    $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    fb_write_t want;
    if (!rst_ni) begin
      origin_x    = '0;
      origin_y    = '0;
      image_cols  = CFG_W'(1);
      image_rows  = CFG_W'(1);
      screen_cols = CFG_W'(1920);
      screen_rows = CFG_W'(1080);
      darken      = 1'b0;
      factor      = FACTOR_ONE;
      col_pos     = 0;
      row_pos     = 0;
      failures    = 0;
      owed_writes.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Register writes; unknown indexes change nothing.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORIGIN_X:     origin_x = cfg_data_i;
          REG_ORIGIN_Y:     origin_y = cfg_data_i;
          REG_IMAGE_COLS:   image_cols = cfg_data_i;
          REG_IMAGE_ROWS:   image_rows = cfg_data_i;
          REG_SCREEN_COLS:  screen_cols = cfg_data_i;
          REG_SCREEN_ROWS:  screen_rows = cfg_data_i;
          REG_DARKEN_MODE:  darken = cfg_data_i[0];
          REG_SCALE_FACTOR: factor = cfg_data_i[FACTOR_W-1:0];
          default: ;
        endcase
      end

      // Output request against the oldest owed write.
      if (out_valid_i && !out_stall_i) begin
        if (owed_writes.size() == 0) begin
          report_mismatch("out_valid", '0, PIX_W'(1));
        end else begin
          want = owed_writes.pop_front();
          if (target_index_i !== want.index) begin
            report_mismatch("target_index", PIX_W'(want.index), PIX_W'(target_index_i));
          end
          if (target_pixel_i !== want.pixel) begin
            report_mismatch("target_pixel", want.pixel, target_pixel_i);
          end
        end
      end

      // Input request: predict, then step through the image in raster order.
      if (in_valid_i && !in_stall_i) begin
        if (blit_target(source_pixel_i, want)) owed_writes.push_back(want);
        if (col_pos + 1 >= clamp_dim(image_cols, 1)) begin
          col_pos = 0;
          if (row_pos + 1 >= clamp_dim(image_rows, 1)) row_pos = 0;
          else row_pos++;
        end else begin
          col_pos++;
        end
      end

      pending_o    <= owed_writes.size();
      fail_count_o <= failures;
    end
  end

endmodule

FILE: verif/clipped_blit_with_darken_test.sv
`timescale 1ns / 1ps

module clipped_blit_with_darken_test;
  import cbd_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PIXELS = 1950;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;

  // Indexes outside the register list, which the block must ignore.
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = 4'd8;
  localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_REG  = 4'd15;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     source_pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TIDX_W-1:0]    target_index;
  logic [PIX_W-1:0]     target_pixel;
  int                   fail_count;
  int                   pending_count;
  int                   cycles = 0;
  bit                   quiet = 1'b0;

  clipped_blit_with_darken dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .source_pixel_i (source_pixel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .target_index_o (target_index),
    .target_pixel_o (target_pixel)
  );

  clipped_blit_with_darken_checker blit_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .source_pixel_i (source_pixel),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .target_index_i (target_index),
    .target_pixel_i (target_pixel),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[clipped_blit_with_darken] ERROR");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long; none in quiet phases.
  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Signed origin, mostly near the screen so that clipping is partial.
  function automatic logic [CFG_W-1:0] pick_origin(input int span);
    case ($urandom_range(0, 15))
      0:       return CFG_W'(-4096);
      1:       return CFG_W'(4095);
      2:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, span + 4) - 4);
    endcase
  endfunction

  // Size register, mostly small, sometimes zero, maximum or oversized.
  function automatic logic [CFG_W-1:0] pick_dim(input int span);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'(4096);
      2:       return CFG_W'(4097);
      3:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1, span));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_mode();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return CFG_W'($urandom);
    return (roll < 7) ? CFG_W'(1) : CFG_W'(0);
  endfunction

  function automatic logic [CFG_W-1:0] pick_factor();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CFG_W'(256);
      2:       return CFG_W'(511);
      3:       return CFG_W'(255);
      4:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return 32'h00FF_FFFF;
      default: return 32'hFF00_0000;
    endcase
  endfunction

  // One register write; the caller drops the write enable after a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Load every register, sometimes followed by a write to an unused index.
  task automatic setup_blit(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
                            input logic [CFG_W-1:0] icols, input logic [CFG_W-1:0] irows,
                            input logic [CFG_W-1:0] scols, input logic [CFG_W-1:0] srows,
                            input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] fac);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_IMAGE_COLS, icols);
    write_reg(REG_IMAGE_ROWS, irows);
    write_reg(REG_SCREEN_COLS, scols);
    write_reg(REG_SCREEN_ROWS, srows);
    write_reg(REG_DARKEN_MODE, mode);
    write_reg(REG_SCALE_FACTOR, fac);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(FIRST_UNUSED_REG + CFG_IDX_W'($urandom_range(0, 7)), CFG_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one source pixel request after an optional gap and wait until taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    source_pixel <= pix;
    do @(posedge clk); while (in_stall);
  endtask

  // Let every owed write come out, then give the block time to settle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output stall: random stall bursts between short runs without stall.
  initial begin : stall_gen
    int hold;
    @(posedge rst_n);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int sent;
    int burst;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: a 1 x 1 image copied to index 0.
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    settle();

    // Largest screen, origin at its last pixel: only the first pixel lands,
    // at the top index; an oversized factor acts as 1.0.
    setup_blit(13'd4095, 13'd4095, 13'd2, 13'd2, 13'd4096, 13'd4096, 13'd1, 13'd511);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    send_pixel(32'h9ABC_DEF0);
    send_pixel(32'h0F0F_0F0F);
    settle();

    // Origin at -1, -1: only the last pixel of a 2 x 2 image lands.
    setup_blit(13'h1FFF, 13'h1FFF, 13'd2, 13'd2, 13'd1920, 13'd1080, 13'd0, 13'd256);
    send_pixel(32'hA5A5_A5A5);
    send_pixel(32'h5A5A_5A5A);
    send_pixel(32'hFF00_FF00);
    send_pixel(32'h00FF_00FF);
    settle();

    // Origin at the far left, oversized image and screen widths.
    setup_blit(13'h1000, 13'd0, 13'h1FFF, 13'd0, 13'h1FFF, 13'd1, 13'd1, 13'd0);
    send_pixel(32'h8080_8080);
    send_pixel(32'h7F7F_7F7F);
    send_pixel(32'hFFFF_FFFF);
    settle();

    // A zero screen width hides everything; the image position still moves.
    setup_blit(13'd0, 13'd0, 13'd0, 13'd4097, 13'd0, 13'd8, 13'd1, 13'd128);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0102_0304);
    settle();

    // A zero screen height hides everything too.
    setup_blit(13'd0, 13'd0, 13'd3, 13'd1, 13'd8, 13'd0, 13'd1, 13'd1);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hDEAD_BEEF);
    settle();

    // Smallest nonzero factor on a one-column image; an unused index first.
    write_reg(LAST_UNUSED_REG, '1);
    setup_blit(13'd5, 13'd2, 13'd1, 13'd3, 13'd8, 13'd8, 13'd1, 13'd1);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00FF_8001);
    send_pixel(32'hFF01_FF01);
    settle();

    // Half and zero brightness.
    setup_blit(13'd0, 13'd0, 13'd1, 13'd1, 13'd8, 13'd8, 13'd1, 13'd128);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1281_FE03);
    settle();
    setup_blit(13'd0, 13'd0, 13'd1, 13'd1, 13'd8, 13'd8, 13'd1, 13'd0);
    send_pixel(32'hFFFF_FFFF);
    settle();

    // Random phases: new settings, then a burst of random pixels.
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      quiet = ($urandom_range(0, 4) == 0);
      setup_blit(pick_origin(40), pick_origin(20), pick_dim(12), pick_dim(6),
                 pick_dim(48), pick_dim(24), pick_mode(), pick_factor());
      burst = $urandom_range(8, 60);
      repeat (burst) begin
        send_pixel(pick_pixel());
        sent++;
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[clipped_blit_with_darken] OK");
    end else begin
      $display("[clipped_blit_with_darken] ERROR");
    end
    $finish;
  end

endmodule
